>>> hw/rtl/gpdc_pkg.sv
package gpdc_pkg;

	localparam int XY_W    = 24;
	localparam int HD_W    = 16;
	localparam int D_W     = 25;
	localparam int SQ_W    = 49;
	localparam int N_W     = 50;
	localparam int VX_W    = 43;
	localparam int Z_W     = 24;
	localparam int ERR_W   = 22;
	localparam int CX_W    = 33;
	localparam int COS_W   = 31;
	localparam int PROD_W  = 56;
	localparam int SPD_W   = 23;
	localparam int TRN_W   = 16;
	localparam int TLIM_W  = 15;
	localparam int SQRT_STEPS = 25;

	localparam logic signed [ERR_W-1:0] ANG_PI_Q13      = 22'sd25736;
	localparam logic signed [ERR_W-1:0] ANG_HALF_PI_Q13 = 22'sd12868;
	localparam logic signed [ERR_W-1:0] ANG_TWO_PI_Q13  = 22'sd51472;
	localparam logic signed [Z_W-1:0]   ANG_HALF_PI_Q16 = 24'sd102944;
	localparam logic signed [CX_W-1:0]  CORDIC_K_Q30    = 33'sd652032874;
	localparam logic [COS_W-1:0]        ONE_Q30         = 31'd1073741824;
	localparam logic [N_W-1:0]          CLOSE_D2        = 50'd16;

	localparam logic REG_SPEED_LIMIT = 1'b0;
	localparam logic REG_TURN_LIMIT  = 1'b1;

	typedef struct packed {
		logic                     gv;
		logic signed [HD_W-1:0]   hd;
		logic signed [D_W-1:0]    dx;
		logic signed [D_W-1:0]    dy;
		logic [SQ_W-1:0]          sqx;
		logic [SQ_W-1:0]          sqy;
		logic [N_W-1:0]           n;
		logic [N_W-1:0]           r;
		logic                     close;
		logic signed [VX_W-1:0]   vx;
		logic signed [VX_W-1:0]   vy;
		logic signed [Z_W-1:0]    vz;
		logic signed [ERR_W-1:0]  err;
		logic signed [TRN_W-1:0]  turn;
		logic                     cosok;
		logic signed [CX_W-1:0]   cx;
		logic signed [CX_W-1:0]   cy;
		logic signed [Z_W-1:0]    cz;
		logic [COS_W-1:0]         cosv;
		logic [PROD_W-1:0]        prod;
		logic [SPD_W-1:0]         speed;
	} bundle_t;

	function automatic logic signed [Z_W-1:0] atan_q16(input int i);
		logic signed [Z_W-1:0] v;
		case (i)
			0: v = 24'sd51472;
			1: v = 24'sd30386;
			2: v = 24'sd16055;
			3: v = 24'sd8150;
			4: v = 24'sd4091;
			5: v = 24'sd2047;
			6: v = 24'sd1024;
			7: v = 24'sd512;
			8: v = 24'sd256;
			9: v = 24'sd128;
			10: v = 24'sd64;
			11: v = 24'sd32;
			12: v = 24'sd16;
			13: v = 24'sd8;
			14: v = 24'sd4;
			15: v = 24'sd2;
			16: v = 24'sd1;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

>>> hw/rtl/goal_pursuit_drive_command_core.sv
// Go-to-goal drive command: each pose item yields one item holding a forward speed and a
// turn rate. The datapath is a fully pipelined chain of registers: a vectoring CORDIC for
// the goal bearing is followed by a rotation CORDIC for the cosine of the heading error,
// and a restoring square root of one bit per stage for the distance runs beside them. A
// new item is taken every cycle while the output is not stalled; the pipeline depth is
// set by the two CORDIC chains or by the 25 square-root stages, whichever is longer. A
// stall on the output holds the whole pipeline.
module goal_pursuit_drive_command_core #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// robot_x, robot_y, robot_heading, goal_x, goal_y
	input  logic [111:0] s_tdata,
	// goal_valid
	input  logic [0:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// forward_speed, turn_rate, one zero pad bit
	output logic [39:0]  m_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [0:0]   cfg_index,
	input  logic [22:0]  cfg_data
);
	import gpdc_pkg::*;

	localparam int NS   = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
	localparam int V0   = 3;
	localparam int ES   = V0 + NS;
	localparam int R0   = ES + 1;
	localparam int CS   = R0 + NS;
	localparam int Q0   = 4;
	localparam int QE   = Q0 + SQRT_STEPS - 1;
	localparam int MS   = ((CS + 1) > (QE + 1)) ? (CS + 1) : (QE + 1);
	localparam int L    = MS + 1;

	logic [SPD_W-1:0]  speed_limit_q;
	logic [TLIM_W-1:0] turn_limit_q;
	bundle_t b [0:L];
	bundle_t nx [1:L];
	logic [L:1] vld_s;
	logic adv;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_limit_q <= SPD_W'(4096);
			turn_limit_q  <= TLIM_W'(8192);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SPEED_LIMIT: speed_limit_q <= cfg_data;
				REG_TURN_LIMIT:  turn_limit_q  <= cfg_data[TLIM_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv      = !vld_s[L] || m_tready;
	assign s_tready = adv;

	always_comb begin
		b[0]    = '0;
		b[0].gv = s_tuser[0];
		b[0].hd = s_tdata[63:48];
		b[0].dx = D_W'($signed(s_tdata[87:64])) - D_W'($signed(s_tdata[23:0]));
		b[0].dy = D_W'($signed(s_tdata[111:88])) - D_W'($signed(s_tdata[47:24]));
	end

	for (genvar g = 1; g <= L; g++) begin : g_stage
		localparam int VI = (g >= V0) ? (g - V0) : 0;
		localparam int RI = (g >= R0) ? (g - R0) : 0;
		localparam int QI = (g >= Q0) ? (g - Q0) : 0;
		localparam logic [N_W-1:0] QBIT = N_W'(1) << (2 * (SQRT_STEPS - 1 - QI));

		always_comb begin
			bundle_t p;
			logic signed [VX_W-1:0] xs, ys;
			logic signed [CX_W-1:0] cxs, cys;
			logic [N_W:0] qt;
			logic signed [ERR_W-1:0] bear, e;
			logic signed [ERR_W:0] t2, lim;
			logic [PROD_W-31:0] sp;
			p = b[g-1];
			xs = '0; ys = '0; cxs = '0; cys = '0; qt = '0;
			bear = '0; e = '0; t2 = '0; lim = '0; sp = '0;
			if (g == 1) begin
				p.sqx = SQ_W'(p.dx * p.dx);
				p.sqy = SQ_W'(p.dy * p.dy);
			end
			if (g == 2) begin
				p.vx = VX_W'(p.dx) <<< 16;
				p.vy = VX_W'(p.dy) <<< 16;
				p.vz = '0;
				if (p.vx < 0) begin
					if (p.vy >= 0) begin
						p.vx = VX_W'(p.dy) <<< 16;
						p.vy = -(VX_W'(p.dx) <<< 16);
						p.vz = ANG_HALF_PI_Q16;
					end else begin
						p.vx = -(VX_W'(p.dy) <<< 16);
						p.vy = VX_W'(p.dx) <<< 16;
						p.vz = -ANG_HALF_PI_Q16;
					end
				end
				p.n = N_W'(p.sqx) + N_W'(p.sqy);
				p.r = '0;
			end
			if (g == 3) begin
				p.close = (p.n <= CLOSE_D2);
			end
			if (g >= V0 && g < V0 + NS) begin
				xs = p.vx >>> VI;
				ys = p.vy >>> VI;
				if (p.vy > 0) begin
					p.vx = p.vx + ys;
					p.vy = p.vy - xs;
					p.vz = p.vz + atan_q16(VI);
				end else begin
					p.vx = p.vx - ys;
					p.vy = p.vy + xs;
					p.vz = p.vz - atan_q16(VI);
				end
			end
			if (g >= Q0 && g <= QE) begin
				qt = {1'b0, p.r} + {1'b0, QBIT};
				if ({1'b0, p.n} >= qt) begin
					p.n = p.n - qt[N_W-1:0];
					p.r = (p.r >> 1) + QBIT;
				end else begin
					p.r = p.r >> 1;
				end
			end
			if (g == ES) begin
				bear = ERR_W'((p.vz + Z_W'(4)) >>> 3);
				e = bear - ERR_W'(p.hd);
				if (e > ANG_PI_Q13) begin
					e = e - ANG_TWO_PI_Q13;
				end else if (e < -ANG_PI_Q13) begin
					e = e + ANG_TWO_PI_Q13;
				end
				p.err = e;
				p.cosok = (e < ANG_HALF_PI_Q13) && (e > -ANG_HALF_PI_Q13);
				t2 = (ERR_W+1)'(e) <<< 1;
				lim = (ERR_W+1)'({1'b0, turn_limit_q});
				if (t2 > lim) begin
					t2 = lim;
				end else if (t2 < -lim) begin
					t2 = -lim;
				end
				p.turn = t2[TRN_W-1:0];
				p.cx = CORDIC_K_Q30;
				p.cy = '0;
				p.cz = Z_W'(e) <<< 3;
			end
			if (g >= R0 && g < R0 + NS) begin
				cxs = p.cx >>> RI;
				cys = p.cy >>> RI;
				if (p.cz >= 0) begin
					p.cx = p.cx - cys;
					p.cy = p.cy + cxs;
					p.cz = p.cz - atan_q16(RI);
				end else begin
					p.cx = p.cx + cys;
					p.cy = p.cy - cxs;
					p.cz = p.cz + atan_q16(RI);
				end
			end
			if (g == CS) begin
				if (p.cx < 0) begin
					p.cosv = '0;
				end else if (p.cx > $signed({2'b00, ONE_Q30})) begin
					p.cosv = ONE_Q30;
				end else begin
					p.cosv = p.cx[COS_W-1:0];
				end
			end
			if (g == MS) begin
				p.prod = PROD_W'(p.cosv) * PROD_W'(p.r[D_W-1:0]);
			end
			if (g == L) begin
				sp = p.prod[PROD_W-1:30];
				if (!p.gv || p.close || !p.cosok) begin
					p.speed = '0;
				end else if (sp > (PROD_W-30)'(speed_limit_q)) begin
					p.speed = speed_limit_q;
				end else begin
					p.speed = sp[SPD_W-1:0];
				end
				if (!p.gv || p.close) begin
					p.turn = '0;
				end
			end
			nx[g] = p;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				b[g] <= nx[g];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (adv) begin
				vld_s[g] <= (g == 1) ? s_tvalid : vld_s[(g > 1) ? g - 1 : 1];
			end
		end
	end

	assign m_tvalid = vld_s[L];
	assign m_tdata  = {1'b0, b[L].turn, b[L].speed};

endmodule

>>> hw/rtl/gpdc_checker.sv
module gpdc_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [39:0]  m_tdata,
	input logic         cfg_ready
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output item changed while stalled");

	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid || m_tready |-> s_tready)
		else $error("input blocked with a free output");

	a_turn_sym: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[38:23] != 16'h8000 && m_tdata[39] == 1'b0)
		else $error("turn rate outside its symmetric range");

	a_cfg: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration port not ready");

endmodule

bind goal_pursuit_drive_command_core gpdc_checker u_gpdc_checker (
	.clk(clk), .arst_n(arst_n), .s_tready(s_tready), .m_tvalid(m_tvalid),
	.m_tready(m_tready), .m_tdata(m_tdata), .cfg_ready(cfg_ready)
);

>>> verif/tb_goal_pursuit_drive_command_core.sv
module tb_goal_pursuit_drive_command_core;
	timeunit 1ns;
	timeprecision 1ps;
	import gpdc_pkg::*;

	localparam int STAGES = 16;
	localparam int DRAIN_CYCLES = 45;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam longint HALF_PI_Q13 = 12868;
	localparam longint PI_Q13 = 25736;
	localparam longint TWO_PI_Q13 = 51472;
	localparam longint HALF_PI_Q16 = 102944;
	localparam longint GAIN_Q30 = 652032874;
	localparam longint UNIT_Q30 = 64'd1073741824;
	localparam longint ARCTAN_Q16 [24] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0};

	typedef struct {
		logic [SPD_W-1:0] speed;
		logic signed [TRN_W-1:0] turn;
	} drive_cmd_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [111:0] s_tdata;
	logic [0:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [39:0] m_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic [0:0] cfg_index;
	logic [22:0] cfg_data;

	longint speed_cap;
	longint turn_cap;
	drive_cmd_t pending_cmds[$];
	int mismatches;
	int quiet_cycles;
	bit sink_stalls;
	bit source_gaps;
	int stall_left;

	goal_pursuit_drive_command_core #(.CORDIC_STAGES(STAGES)) u_dut (.*);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic longint root_floor(longint n);
		longint r, b;
		r = 0;
		b = 64'sd1 << 60;
		while (b > n)
			b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint goal_bearing(longint dx, longint dy);
		longint x, y, z, t, xs, ys;
		x = dx * 65536;
		y = dy * 65536;
		z = 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y;
				y = -t;
				z = HALF_PI_Q16;
			end else begin
				x = -y;
				y = t;
				z = -HALF_PI_Q16;
			end
		end
		for (int i = 0; i < STAGES && i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x = x + ys;
				y = y - xs;
				z = z + ARCTAN_Q16[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - ARCTAN_Q16[i];
			end
		end
		return (z + 4) >>> 3;
	endfunction

	function automatic longint error_cosine(longint ang);
		longint x, y, z, xs, ys;
		x = GAIN_Q30;
		y = 0;
		z = ang * 8;
		for (int i = 0; i < STAGES && i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x = x - ys;
				y = y + xs;
				z = z - ARCTAN_Q16[i];
			end else begin
				x = x + ys;
				y = y - xs;
				z = z + ARCTAN_Q16[i];
			end
		end
		if (x < 0)
			x = 0;
		if (x > UNIT_Q30)
			x = UNIT_Q30;
		return x;
	endfunction

	function automatic drive_cmd_t drive_command(logic [111:0] pose, logic gv);
		drive_cmd_t cmd;
		longint dx, dy, d2, span, err, turn, speed;
		cmd.speed = '0;
		cmd.turn = '0;
		dx = longint'($signed(pose[87:64])) - longint'($signed(pose[23:0]));
		dy = longint'($signed(pose[111:88])) - longint'($signed(pose[47:24]));
		d2 = dx * dx + dy * dy;
		if (!gv || d2 <= 16)
			return cmd;
		span = root_floor(d2);
		err = goal_bearing(dx, dy) - longint'($signed(pose[63:48]));
		if (err > PI_Q13)
			err = err - TWO_PI_Q13;
		else if (err < -PI_Q13)
			err = err + TWO_PI_Q13;
		turn = 2 * err;
		if (turn > turn_cap)
			turn = turn_cap;
		if (turn < -turn_cap)
			turn = -turn_cap;
		speed = 0;
		if (err < HALF_PI_Q13 && err > -HALF_PI_Q13)
			speed = (error_cosine(err) * span) >> 30;
		if (speed > speed_cap)
			speed = speed_cap;
		cmd.speed = speed[SPD_W-1:0];
		cmd.turn = turn[TRN_W-1:0];
		return cmd;
	endfunction

	always @(posedge clk) begin
		drive_cmd_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				pending_cmds.push_back(drive_command(s_tdata, s_tuser[0]));
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_SPEED_LIMIT)
					speed_cap = cfg_data;
				else
					turn_cap = cfg_data[TLIM_W-1:0];
			end
			if (m_tvalid && m_tready) begin
				if (pending_cmds.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected item: %h", m_tdata);
				end else begin
					want = pending_cmds.pop_front();
					if (m_tdata[22:0] !== want.speed || m_tdata[38:23] !== want.turn) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: speed exp %0d got %0d, turn exp %0d got %0d",
								want.speed, m_tdata[22:0], want.turn,
								$signed(m_tdata[38:23]));
					end
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	always @(negedge clk) begin
		if (!sink_stalls) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 12);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic send_pose(logic [23:0] rx, logic [23:0] ry, logic [15:0] hd,
		logic [23:0] gx, logic [23:0] gy, logic gv);
		bit ready_now;
		if (source_gaps && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {gy, gx, hd, ry, rx};
		s_tuser <= gv;
		do begin
			#1;
			ready_now = s_tready;
			@(posedge clk);
			if (!ready_now)
				@(negedge clk);
		end while (!ready_now);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_cmds.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_limit(logic [0:0] idx, logic [22:0] value);
		bit ready_now;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do begin
			#1;
			ready_now = cfg_ready;
			@(posedge clk);
			if (!ready_now)
				@(negedge clk);
		end while (!ready_now);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_random_pose();
		logic [23:0] rx, ry, gx, gy;
		logic [15:0] hd;
		int reach;
		rx = $urandom;
		ry = $urandom;
		reach = $urandom_range(0, 23);
		gx = rx + (24'($signed($urandom)) >>> reach);
		gy = ry + (24'($signed($urandom)) >>> reach);
		if ($urandom_range(0, 9) == 0)
			hd = $urandom;
		else
			hd = 16'($signed($urandom_range(0, 2 * 25736)) - 25736);
		if ($urandom_range(0, 19) == 0) begin
			gx = $urandom;
			gy = $urandom;
		end
		send_pose(rx, ry, hd, gx, gy, $urandom_range(0, 15) != 0);
	endtask

	task automatic test_special_poses();
		send_pose(24'd100, 24'd200, 16'd0, 24'd90000, 24'd5000, 1'b0);
		send_pose(24'd0, 24'd0, 16'd0, 24'd0, 24'd0, 1'b1);
		send_pose(24'd0, 24'd0, 16'd0, 24'd4, 24'd0, 1'b1);
		send_pose(24'd0, 24'd0, 16'd0, 24'd3, 24'd3, 1'b1);
		send_pose(24'd0, 24'd0, 16'd0, 24'd5000, 24'd0, 1'b1);
		send_pose(24'd0, 24'd0, 16'd12868, 24'd5000, 24'd0, 1'b1);
		send_pose(24'd0, 24'd0, -16'sd12868, 24'd5000, 24'd0, 1'b1);
		send_pose(24'd0, 24'd0, 16'd25736, 24'd5000, 24'd0, 1'b1);
		send_pose(24'd0, 24'd0, -16'sd25736, -24'sd5000, 24'd1, 1'b1);
		send_pose(24'd0, 24'd0, 16'h7fff, -24'sd5000, -24'sd1, 1'b1);
		send_pose(24'd0, 24'd0, 16'h8000, 24'd0, 24'd5000, 1'b1);
		send_pose(24'h800000, 24'h800000, 16'd0, 24'h7fffff, 24'h7fffff, 1'b1);
		send_pose(24'h7fffff, 24'h7fffff, 16'd0, 24'h800000, 24'h800000, 1'b1);
		send_pose(24'h800000, 24'h7fffff, 16'd100, 24'h7fffff, 24'h800000, 1'b1);
		send_pose(24'd0, 24'd0, 16'd0, 24'd0, -24'sd5000, 1'b1);
		send_pose(24'd0, 24'd0, 16'd0, 24'd2000, 24'd2000, 1'b1);
		send_pose(24'hffffff, 24'hffffff, 16'hffff, 24'hffffff, 24'hffffff, 1'b1);
		wait_idle();
	endtask

	task automatic test_limit_settings();
		logic [22:0] speeds[4] = '{23'd0, 23'h7fffff, 23'd1, 23'd4096};
		logic [14:0] turns[4] = '{15'h7fff, 15'd0, 15'd1, 15'd8192};
		for (int k = 0; k < 4; k++) begin
			write_limit(REG_SPEED_LIMIT, speeds[k]);
			write_limit(REG_TURN_LIMIT, {8'd0, turns[k]});
			repeat (40) send_random_pose();
			wait_idle();
		end
	endtask

	task automatic test_random_poses(int count);
		repeat (count) send_random_pose();
	endtask

	task automatic test_drain_pause();
		wait_idle();
		write_limit(REG_SPEED_LIMIT, 23'h7fffff);
		write_limit(REG_TURN_LIMIT, 23'h7fff);
		repeat (30) send_random_pose();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		speed_cap = 4096;
		turn_cap = 8192;
		mismatches = 0;
		quiet_cycles = 0;
		stall_left = 0;
		sink_stalls = 1'b1;
		source_gaps = 1'b1;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_special_poses();
		test_limit_settings();
		test_random_poses(750);
		test_drain_pause();
		sink_stalls = 1'b0;
		source_gaps = 1'b0;
		test_random_poses(250);
		wait_idle();
		if (mismatches == 0 && pending_cmds.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule

>>> filelist.f
hw/rtl/gpdc_pkg.sv
hw/rtl/goal_pursuit_drive_command_core.sv
hw/rtl/gpdc_checker.sv
verif/tb_goal_pursuit_drive_command_core.sv
